// ===== rtl/bpc_pkg.sv =====
// shared constants and types for the button press classifier
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

  localparam int TIMER_BITS_DEF = 20;
  localparam int SHORT_IDLE_MS = 10000;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 20;
  localparam int LONG_W = 20;
  localparam int SPAN_W = 20;
  localparam int MS_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DOUBLE_EN = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_START = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_INTERVAL = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_DOUBLE_WINDOW = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_RAMP_SPAN = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_RAMP_FINAL = 3'd7;

  localparam logic [MS_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [MS_W-1:0] REPEAT_START_RST = 16'd500;
  localparam logic [MS_W-1:0] REPEAT_INTERVAL_RST = 16'd100;
  localparam logic [MS_W-1:0] DOUBLE_WINDOW_RST = 16'd300;
  localparam logic [MS_W-1:0] RAMP_FINAL_RST = 16'd100;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_DOUBLE = 2'd3
  } press_event_t;

endpackage
`default_nettype wire

// ===== rtl/bpc_if.sv =====
// handshake channel interfaces for samples, events and configuration
`timescale 1ns / 1ps
`default_nettype none
interface bpc_in_if;
  logic valid;
  logic ready;
  logic button_down;
  modport source (output valid, output button_down, input ready);
  modport sink (input valid, input button_down, output ready);
endinterface

interface bpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] press_event;
  modport source (output valid, output press_event, input ready);
  modport sink (input valid, input press_event, output ready);
endinterface

interface bpc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bpc_pkg::CFG_ADDR_W-1:0]   addr;
  logic [bpc_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/button_press_classifier_core.sv =====
// button press classifier: debounce, short/long/double press and autorepeat
//
// Channels: sample carries one button level per millisecond tick, result
// returns exactly one press_event item per sample (none, short, long or
// double), cfg writes the eight control registers by index and is always
// ready; write it only while no sample is in flight.
// Each sample is accepted, passes a multiply state and, when the autorepeat
// ramp interval must be computed, a restoring divider that retires one
// quotient bit per cycle, then a finish state loads the result register.
// sample.ready is high only while the sequencer is idle, so a new sample is
// not taken until the previous one has left the finish state.
// The result register decouples the sides: a new sample is taken while an
// earlier event waits; when the receiver stalls, the finishing sample waits
// in the finish state until the result register frees up.
// Synchronous reset loads register defaults, clears the level, pressed and
// long flags and the timers, and sets the short-press timer to 10000 ms
// (or the timer maximum when narrower).
`timescale 1ns / 1ps
`default_nettype none
module button_press_classifier_core #(
  parameter int TIMER_BITS = bpc_pkg::TIMER_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  bpc_in_if.sink       sample,
  bpc_out_if.source    result,
  bpc_cfg_if.sink      cfg
);

  localparam int CW = (TIMER_BITS > bpc_pkg::LONG_W) ? TIMER_BITS : bpc_pkg::LONG_W;
  localparam int QW = TIMER_BITS + bpc_pkg::MS_W;
  localparam int CNT_W = $clog2(QW);
  localparam int SW = bpc_pkg::SPAN_W;
  localparam int MW = bpc_pkg::MS_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam logic [TIMER_BITS-1:0] SHORT_RST =
    (TIMER_BITS >= 14) ? TIMER_BITS'(bpc_pkg::SHORT_IDLE_MS) : TIMER_MAX;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_t;

  state_t state;

  logic [bpc_pkg::LONG_W-1:0] long_press_ms;
  logic                       double_enable;
  logic [MW-1:0]              debounce_ms;
  logic [MW-1:0]              repeat_start_ms;
  logic [MW-1:0]              repeat_interval_ms;
  logic [MW-1:0]              double_window_ms;
  logic [SW-1:0]              ramp_span_ms;
  logic [MW-1:0]              ramp_final_ms;

  logic                  prior_level;
  logic                  stable_pressed;
  logic                  long_reported;
  logic [TIMER_BITS-1:0] since_change_ms;
  logic [TIMER_BITS-1:0] since_repeat_ms;
  logic [TIMER_BITS-1:0] since_short_ms;

  logic                  cur_level;
  logic [TIMER_BITS-1:0] t_cur;
  logic [TIMER_BITS-1:0] r_cur;
  logic [QW-1:0]         num;
  logic [SW-1:0]         rem;
  logic [CNT_W-1:0]      count;
  logic                  out_valid;
  logic [1:0]            out_event;

  // ramp helpers
  logic          b_ge_a;
  logic [MW-1:0] abs_delta;
  logic [CW-1:0] t_ext;
  logic [CW-1:0] r_ext;
  logic [TIMER_BITS-1:0] t_off;
  logic          need_div;
  logic [SW:0]   rem_shift;
  logic          rem_ge;
  logic [MW-1:0] gap;

  // event evaluation
  bpc_pkg::press_event_t ev;
  logic                  lr_next;
  logic                  sp_next;
  logic [TIMER_BITS-1:0] rep_next;
  logic [TIMER_BITS-1:0] ss_next;
  logic                  out_free;

  assign b_ge_a = ramp_final_ms >= repeat_interval_ms;
  assign abs_delta = b_ge_a ? ramp_final_ms - repeat_interval_ms
                            : repeat_interval_ms - ramp_final_ms;
  assign t_ext = CW'(t_cur);
  assign r_ext = CW'(r_cur);
  assign t_off = TIMER_BITS'(t_ext - CW'(repeat_start_ms));
  assign need_div = cur_level && (t_ext >= CW'(debounce_ms)) && (long_press_ms == '0)
                    && (t_ext > CW'(repeat_start_ms)) && (ramp_span_ms != '0);

  assign rem_shift = {rem, num[QW-1]};
  assign rem_ge = rem_shift >= {1'b0, ramp_span_ms};

  always_comb begin
    if (ramp_span_ms == '0) begin
      gap = repeat_interval_ms;
    end else if (num >= QW'(abs_delta)) begin
      gap = ramp_final_ms;
    end else if (b_ge_a) begin
      gap = repeat_interval_ms + num[MW-1:0];
    end else begin
      gap = repeat_interval_ms - num[MW-1:0];
    end
  end

  always_comb begin
    ev = bpc_pkg::EV_NONE;
    lr_next = long_reported;
    sp_next = stable_pressed;
    rep_next = r_cur;
    ss_next = since_short_ms;
    if (t_ext >= CW'(debounce_ms)) begin
      if (cur_level) begin
        if ((long_press_ms != '0) && (t_ext >= CW'(long_press_ms)) && !long_reported) begin
          ev = bpc_pkg::EV_LONG;
          lr_next = 1'b1;
        end
        if ((long_press_ms == '0) && !stable_pressed) begin
          ev = bpc_pkg::EV_SHORT;
        end
        if ((long_press_ms == '0) && (t_ext > CW'(repeat_start_ms))
            && (r_ext > CW'(gap))) begin
          ev = bpc_pkg::EV_SHORT;
          rep_next = '0;
        end
      end else begin
        if (stable_pressed && !long_reported) begin
          if (double_enable && (CW'(since_short_ms) < CW'(double_window_ms))) begin
            ev = bpc_pkg::EV_DOUBLE;
          end else if (long_press_ms != '0) begin
            ss_next = '0;
            ev = bpc_pkg::EV_SHORT;
          end
        end
        lr_next = 1'b0;
      end
      sp_next = cur_level;
    end
  end

  assign out_free = !out_valid || result.ready;

  assign sample.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign result.valid = out_valid;
  assign result.press_event = out_event;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      long_press_ms <= '0;
      double_enable <= 1'b0;
      debounce_ms <= bpc_pkg::DEBOUNCE_RST;
      repeat_start_ms <= bpc_pkg::REPEAT_START_RST;
      repeat_interval_ms <= bpc_pkg::REPEAT_INTERVAL_RST;
      double_window_ms <= bpc_pkg::DOUBLE_WINDOW_RST;
      ramp_span_ms <= '0;
      ramp_final_ms <= bpc_pkg::RAMP_FINAL_RST;
      prior_level <= 1'b0;
      stable_pressed <= 1'b0;
      long_reported <= 1'b0;
      since_change_ms <= '0;
      since_repeat_ms <= '0;
      since_short_ms <= SHORT_RST;
    end else begin
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid) begin
        unique case (cfg.addr)
          bpc_pkg::REG_LONG_PRESS:      long_press_ms <= cfg.data[bpc_pkg::LONG_W-1:0];
          bpc_pkg::REG_DOUBLE_EN:       double_enable <= cfg.data[0];
          bpc_pkg::REG_DEBOUNCE:        debounce_ms <= cfg.data[MW-1:0];
          bpc_pkg::REG_REPEAT_START:    repeat_start_ms <= cfg.data[MW-1:0];
          bpc_pkg::REG_REPEAT_INTERVAL: repeat_interval_ms <= cfg.data[MW-1:0];
          bpc_pkg::REG_DOUBLE_WINDOW:   double_window_ms <= cfg.data[MW-1:0];
          bpc_pkg::REG_RAMP_SPAN:       ramp_span_ms <= cfg.data[SW-1:0];
          bpc_pkg::REG_RAMP_FINAL:      ramp_final_ms <= cfg.data[MW-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            cur_level <= sample.button_down;
            if (sample.button_down != prior_level) begin
              t_cur <= '0;
              r_cur <= '0;
            end else begin
              t_cur <= since_change_ms;
              r_cur <= since_repeat_ms;
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          num <= QW'(t_off) * QW'(abs_delta);
          rem <= '0;
          count <= CNT_W'(QW - 1);
          state <= need_div ? S_DIV : S_FIN;
        end
        S_DIV: begin
          num <= {num[QW-2:0], rem_ge};
          rem <= rem_ge ? SW'(rem_shift - {1'b0, ramp_span_ms}) : rem_shift[SW-1:0];
          count <= count - 1'b1;
          if (count == '0) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_event <= ev;
            prior_level <= cur_level;
            stable_pressed <= sp_next;
            long_reported <= lr_next;
            since_change_ms <= (t_cur == TIMER_MAX) ? t_cur : t_cur + 1'b1;
            since_repeat_ms <= (rep_next == TIMER_MAX) ? rep_next : rep_next + 1'b1;
            since_short_ms <= (ss_next == TIMER_MAX) ? ss_next : ss_next + 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bpc_checker.sv =====
// port-level checks for the button press classifier, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module bpc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_event
);

  // stalled event holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_event))
    else $error("event changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while busy");

  // reset leaves the block idle with no event pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("not idle after reset");

  // a new event only appears at the end of a sample's work
  a_event_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("event without a sample in flight");

endmodule

bind button_press_classifier_core bpc_checker u_bpc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_event (result.press_event)
);
`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for button_press_classifier_core with an in-bench event predictor
`timescale 1ns / 1ps
module tb;
  import bpc_pkg::*;

  localparam int TB = TIMER_BITS_DEF;
  localparam int SETTLE_CYCLES = 50;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst;

  bpc_in_if sample_ch ();
  bpc_out_if event_ch ();
  bpc_cfg_if cfg_ch ();

  button_press_classifier_core uut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (event_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor configuration
  logic [LONG_W-1:0] cfg_long_ms;
  logic              cfg_double_en;
  logic [MS_W-1:0]   cfg_debounce_ms;
  logic [MS_W-1:0]   cfg_repeat_start_ms;
  logic [MS_W-1:0]   cfg_repeat_interval_ms;
  logic [MS_W-1:0]   cfg_double_window_ms;
  logic [SPAN_W-1:0] cfg_ramp_span_ms;
  logic [MS_W-1:0]   cfg_ramp_final_ms;

  // predictor state
  bit          last_level;
  bit          held_state;
  bit          long_sent;
  logic [TB-1:0] ms_since_edge;
  logic [TB-1:0] ms_since_repeat;
  logic [TB-1:0] ms_since_short;

  press_event_t expected_events[$];

  int errors;
  int samples_sent;
  int events_checked;
  int reg_writes;
  int seen_by_kind[4];
  int quiet_cycles;
  bit no_gaps;

  function automatic void reset_predictor();
    cfg_long_ms = '0;
    cfg_double_en = 1'b0;
    cfg_debounce_ms = DEBOUNCE_RST;
    cfg_repeat_start_ms = REPEAT_START_RST;
    cfg_repeat_interval_ms = REPEAT_INTERVAL_RST;
    cfg_double_window_ms = DOUBLE_WINDOW_RST;
    cfg_ramp_span_ms = '0;
    cfg_ramp_final_ms = RAMP_FINAL_RST;
    last_level = 1'b0;
    held_state = 1'b0;
    long_sent = 1'b0;
    ms_since_edge = '0;
    ms_since_repeat = '0;
    ms_since_short = (SHORT_IDLE_MS > (2 ** TB) - 1) ? '1 : TB'(SHORT_IDLE_MS);
  endfunction

  function automatic void apply_reg(input logic [CFG_ADDR_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_LONG_PRESS:      cfg_long_ms = data[LONG_W-1:0];
      REG_DOUBLE_EN:       cfg_double_en = data[0];
      REG_DEBOUNCE:        cfg_debounce_ms = data[MS_W-1:0];
      REG_REPEAT_START:    cfg_repeat_start_ms = data[MS_W-1:0];
      REG_REPEAT_INTERVAL: cfg_repeat_interval_ms = data[MS_W-1:0];
      REG_DOUBLE_WINDOW:   cfg_double_window_ms = data[MS_W-1:0];
      REG_RAMP_SPAN:       cfg_ramp_span_ms = data[SPAN_W-1:0];
      REG_RAMP_FINAL:      cfg_ramp_final_ms = data[MS_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [TB-1:0] sat_inc(input logic [TB-1:0] t);
    return (t == '1) ? t : t + 1'b1;
  endfunction

  // linear ramp of the repeat interval, clamped between start and final interval
  function automatic longint ramp_interval();
    longint a;
    longint b;
    longint tc;
    longint ts;
    longint span;
    longint v;
    longint lo;
    longint hi;
    a = cfg_repeat_interval_ms;
    b = cfg_ramp_final_ms;
    tc = ms_since_edge;
    ts = cfg_repeat_start_ms;
    span = cfg_ramp_span_ms;
    if (span == 0) return a;
    v = (tc - ts) * (b - a) / span + a;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (v <= lo) return lo;
    if (v >= hi) return hi;
    return v;
  endfunction

  function automatic press_event_t classify_tick(input bit level);
    press_event_t ev;
    longint since_rep;
    ev = EV_NONE;
    if (level != last_level) begin
      ms_since_edge = '0;
      ms_since_repeat = '0;
      last_level = level;
    end
    if (ms_since_edge >= cfg_debounce_ms) begin
      if (level) begin
        if (cfg_long_ms != 0 && ms_since_edge >= cfg_long_ms && !long_sent) begin
          ev = EV_LONG;
          long_sent = 1'b1;
        end
        if (cfg_long_ms == 0 && !held_state) ev = EV_SHORT;
        if (cfg_long_ms == 0 && ms_since_edge > cfg_repeat_start_ms) begin
          since_rep = ms_since_repeat;
          if (since_rep > ramp_interval()) begin
            ev = EV_SHORT;
            ms_since_repeat = '0;
          end
        end
      end else begin
        if (held_state && !long_sent) begin
          if (cfg_double_en && ms_since_short < cfg_double_window_ms) begin
            ev = EV_DOUBLE;
          end else if (cfg_long_ms != 0) begin
            ms_since_short = '0;
            ev = EV_SHORT;
          end
        end
        long_sent = 1'b0;
      end
      held_state = level;
    end
    ms_since_edge = sat_inc(ms_since_edge);
    ms_since_repeat = sat_inc(ms_since_repeat);
    ms_since_short = sat_inc(ms_since_short);
    return ev;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_sample(input bit level);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.button_down <= level;
    do @(posedge clk); while (!sample_ch.ready);
    expected_events.push_back(classify_tick(level));
    samples_sent++;
  endtask

  task automatic hold(input bit level, input int ticks);
    for (int k = 0; k < ticks; k++) send_sample(level);
  endtask

  task automatic drain_results();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // press/release pairs of random length, with random single ticks as bounce
  task automatic run_presses(input int count, input int max_hold, input int noise_pct);
    int stop;
    int len;
    stop = samples_sent + count;
    while (samples_sent < stop) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_sample(1'($urandom_range(0, 1)));
      end else begin
        len = $urandom_range(1, max_hold);
        if (len > stop - samples_sent) len = stop - samples_sent;
        hold(1'b1, len);
        len = $urandom_range(1, max_hold);
        if (len > stop - samples_sent) len = stop - samples_sent;
        hold(1'b0, len);
      end
    end
  endtask

  task automatic random_setup(input int long_hi, input int ramp_hi);
    drain_results();
    write_reg(REG_LONG_PRESS,
              CFG_DATA_W'((long_hi == 0) ? 0 : $urandom_range(1, long_hi)));
    write_reg(REG_DOUBLE_EN, CFG_DATA_W'($urandom_range(0, 1)));
    write_reg(REG_DEBOUNCE, CFG_DATA_W'($urandom_range(0, 4)));
    write_reg(REG_REPEAT_START, CFG_DATA_W'($urandom_range(0, 10)));
    write_reg(REG_REPEAT_INTERVAL, CFG_DATA_W'($urandom_range(0, 6)));
    write_reg(REG_DOUBLE_WINDOW, CFG_DATA_W'($urandom_range(0, 40)));
    write_reg(REG_RAMP_SPAN,
              CFG_DATA_W'((ramp_hi == 0) ? 0 : $urandom_range(1, ramp_hi)));
    write_reg(REG_RAMP_FINAL, CFG_DATA_W'($urandom_range(0, 6)));
  endtask

  task automatic test_directed();
    drain_results();
    write_reg(REG_DEBOUNCE, 20'hF0000);
    write_reg(REG_LONG_PRESS, 20'd3);
    write_reg(REG_DOUBLE_EN, 20'd1);
    write_reg(REG_DOUBLE_WINDOW, 20'd12);
    // long press, then short, then two doubles
    hold(1'b1, 5);
    hold(1'b0, 1);
    hold(1'b1, 1);
    hold(1'b0, 1);
    hold(1'b1, 1);
    hold(1'b0, 1);
    hold(1'b1, 2);
    hold(1'b0, 2);
    // autorepeat with masked upper data bits
    drain_results();
    write_reg(REG_LONG_PRESS, 20'd0);
    write_reg(REG_DEBOUNCE, 20'd1);
    write_reg(REG_REPEAT_START, 20'd2);
    write_reg(REG_REPEAT_INTERVAL, 20'hF0001);
    hold(1'b1, 8);
    hold(1'b0, 2);
  endtask

  task automatic test_long_press_mode();
    for (int p = 0; p < 3; p++) begin
      random_setup(12, 0);
      run_presses(50, 18, 15);
    end
  endtask

  task automatic test_autorepeat();
    for (int p = 0; p < 3; p++) begin
      random_setup(0, 0);
      run_presses(35, 20, 10);
    end
  endtask

  task automatic test_ramp();
    for (int p = 0; p < 3; p++) begin
      random_setup(0, 15);
      run_presses(40, 30, 5);
    end
    drain_results();
    write_reg(REG_RAMP_SPAN, 20'hFFFFF);
    write_reg(REG_RAMP_FINAL, 20'd0);
    write_reg(REG_REPEAT_INTERVAL, 20'd5);
    run_presses(30, 30, 5);
  endtask

  task automatic test_double_in_autorepeat();
    random_setup(0, 0);
    write_reg(REG_DOUBLE_EN, 20'd1);
    write_reg(REG_DOUBLE_WINDOW, 20'hFFFF);
    run_presses(40, 12, 10);
  endtask

  task automatic test_extremes();
    // unreachable long press, always double
    drain_results();
    write_reg(REG_DEBOUNCE, 20'd0);
    write_reg(REG_LONG_PRESS, 20'hFFFFF);
    write_reg(REG_DOUBLE_EN, 20'd1);
    write_reg(REG_DOUBLE_WINDOW, 20'hFFFF);
    run_presses(20, 4, 10);
    // debounce never satisfied
    drain_results();
    write_reg(REG_DEBOUNCE, 20'hFFFFF);
    run_presses(10, 4, 20);
    // autorepeat at maximum settings
    drain_results();
    write_reg(REG_DEBOUNCE, 20'd0);
    write_reg(REG_LONG_PRESS, 20'd0);
    write_reg(REG_DOUBLE_EN, 20'hFFFFE);
    write_reg(REG_REPEAT_START, 20'hFFFF);
    write_reg(REG_REPEAT_INTERVAL, 20'hFFFF);
    write_reg(REG_RAMP_SPAN, 20'hFFFFF);
    write_reg(REG_RAMP_FINAL, 20'hFFFF);
    run_presses(10, 6, 0);
    // steep ramp down from the widest interval
    drain_results();
    write_reg(REG_REPEAT_START, 20'd0);
    write_reg(REG_RAMP_SPAN, 20'd1);
    write_reg(REG_RAMP_FINAL, 20'd0);
    run_presses(15, 10, 0);
    // everything zero
    drain_results();
    write_reg(REG_REPEAT_INTERVAL, 20'd0);
    write_reg(REG_RAMP_SPAN, 20'd0);
    write_reg(REG_DOUBLE_WINDOW, 20'd0);
    run_presses(20, 6, 10);
  endtask

  task automatic test_random_mix();
    for (int p = 0; p < 4; p++) begin
      no_gaps = (p % 2 == 1);
      random_setup($urandom_range(0, 1) ? 10 : 0, $urandom_range(0, 1) ? 12 : 0);
      run_presses(15, 16, 25);
      // sender holds back until every event is back
      drain_results();
      run_presses(15, 16, 25);
    end
    no_gaps = 1'b0;
  endtask

  // event sink with random stalls
  initial begin : event_sink
    int stall;
    stall = 0;
    event_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        event_ch.ready <= 1'b0;
        stall--;
      end else begin
        event_ch.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : event_check
    press_event_t want;
    if (!rst && event_ch.valid && event_ch.ready) begin
      if (expected_events.size() == 0) begin
        $display("%0t unexpected event: expected none, actual %0d", $time,
                 event_ch.press_event);
        errors++;
      end else begin
        want = expected_events.pop_front();
        events_checked++;
        seen_by_kind[want]++;
        if (event_ch.press_event !== want) begin
          $display("%0t press_event mismatch: expected %0d, actual %0d", $time, want,
                   event_ch.press_event);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (event_ch.valid && event_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.button_down = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = '0;
    cfg_ch.data = '0;
    errors = 0;
    samples_sent = 0;
    events_checked = 0;
    reg_writes = 0;
    quiet_cycles = 0;
    no_gaps = 1'b0;
    for (int k = 0; k < 4; k++) seen_by_kind[k] = 0;
    reset_predictor();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_long_press_mode();
    test_autorepeat();
    test_ramp();
    test_double_in_autorepeat();
    test_extremes();
    test_random_mix();
    drain_results();

    $display("%0d ticks sent, %0d events checked, %0d register writes", samples_sent,
             events_checked, reg_writes);
    $display("events: %0d none, %0d short, %0d long, %0d double", seen_by_kind[0],
             seen_by_kind[1], seen_by_kind[2], seen_by_kind[3]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bpc_pkg.sv
rtl/bpc_if.sv
rtl/button_press_classifier_core.sv
rtl/bpc_checker.sv
tb/tb.sv
